### sv/a32fb_pkg.sv
// shared types and constants of the adler-32 frame builder
package a32fb_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned SUM_BYTES   = 4;
    localparam int unsigned IDX_W       = 3;

    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] LOW_INIT   = 16'd1;
    localparam logic [15:0] HIGH_INIT  = 16'd0;
    localparam logic [31:0] LEN_EXTRA  = 32'd8;

    localparam logic [7:0] MAGIC_0 = 8'h52;
    localparam logic [7:0] MAGIC_1 = 8'h50;
    localparam logic [7:0] MAGIC_2 = 8'h43;
    localparam logic [7:0] MAGIC_3 = 8'h30;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] arg;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

### sv/adler32_frame_builder_top.sv
// top level of the adler-32 frame builder
// path: an accepted word is written into the queue, then its first byte is registered
// output: a payload word gives 1 byte, a start word 8 bytes, an end word 4 bytes, the
//   serializer emitting one byte per cycle unless stalled by m_tready; unused kinds skip it
// reset: synchronous active-low aresetn empties the queue, drops the output word,
//   and sets the sums to 1 and 0
module adler32_frame_builder_top #(
    parameter int unsigned QUEUE_DEPTH = a32fb_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // payload_length[31:0], data_byte[39:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [0:0]  m_tuser,   // frame_done[0]
    output logic        m_tlast
);

    a32fb_pkg::cmd_t    push_cmd;
    a32fb_pkg::cmd_t    head_cmd;
    a32fb_pkg::q_stat_t q_stat;
    logic               push;
    logic               pop;

    a32fb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    a32fb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    a32fb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/a32fb_front.sv
// front end: accepts input words, drops unused kinds, builds queue commands
module a32fb_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // payload_length[31:0], data_byte[39:32]
    input  logic [1:0]         s_tuser,   // kind[1:0]
    input  a32fb_pkg::q_stat_t q_stat,
    output logic               push,
    output a32fb_pkg::cmd_t    cmd
);

    logic keep;

    always_comb begin
        keep     = 1'b0;
        cmd.kind = a32fb_pkg::kind_t'(s_tuser);
        cmd.arg  = '0;
        unique case (s_tuser)
            a32fb_pkg::KIND_START: begin
                keep    = 1'b1;
                cmd.arg = s_tdata[31:0] + a32fb_pkg::LEN_EXTRA;
            end
            a32fb_pkg::KIND_DATA: begin
                keep    = 1'b1;
                cmd.arg = {24'd0, s_tdata[39:32]};
            end
            a32fb_pkg::KIND_END: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready && keep;

endmodule

### sv/a32fb_queue.sv
// command queue between front end and serializer
module a32fb_queue #(
    parameter int unsigned DEPTH = a32fb_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  a32fb_pkg::cmd_t    push_cmd,
    input  logic               pop,
    output a32fb_pkg::cmd_t    head_cmd,
    output a32fb_pkg::q_stat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    a32fb_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

### sv/a32fb_back.sv
// back end: serializes commands into bytes and keeps the adler-32 sums
module a32fb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  a32fb_pkg::cmd_t    head_cmd,
    input  a32fb_pkg::q_stat_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // out_byte[7:0]
    output logic [0:0]         m_tuser,   // frame_done[0]
    output logic               m_tlast
);

    logic [a32fb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic        advance;
    logic        fire;
    logic [7:0]  byte_sel;
    logic        is_last;
    logic        is_done;
    logic        absorb;
    logic        restart;
    logic        finish;
    logic [15:0] base_low, base_high;
    logic [16:0] low_add, high_add;
    logic [16:0] low_mod, high_mod;

    assign advance = !m_tvalid_reg || m_tready;
    assign fire    = advance && !q_stat.empty;

    always_comb begin
        byte_sel = '0;
        is_last  = 1'b0;
        is_done  = 1'b0;
        absorb   = 1'b0;
        restart  = 1'b0;
        finish   = 1'b0;
        unique case (head_cmd.kind)
            a32fb_pkg::KIND_START: begin
                absorb  = 1'b1;
                restart = (idx_reg == '0);
                is_last = (idx_reg == a32fb_pkg::IDX_W'(a32fb_pkg::HDR_BYTES - 1));
                case (idx_reg)
                    3'd0: byte_sel = head_cmd.arg[31:24];
                    3'd1: byte_sel = head_cmd.arg[23:16];
                    3'd2: byte_sel = head_cmd.arg[15:8];
                    3'd3: byte_sel = head_cmd.arg[7:0];
                    3'd4: byte_sel = a32fb_pkg::MAGIC_0;
                    3'd5: byte_sel = a32fb_pkg::MAGIC_1;
                    3'd6: byte_sel = a32fb_pkg::MAGIC_2;
                    default: byte_sel = a32fb_pkg::MAGIC_3;
                endcase
            end
            a32fb_pkg::KIND_DATA: begin
                absorb   = 1'b1;
                is_last  = 1'b1;
                byte_sel = head_cmd.arg[7:0];
            end
            a32fb_pkg::KIND_END: begin
                is_last = (idx_reg == a32fb_pkg::IDX_W'(a32fb_pkg::SUM_BYTES - 1));
                is_done = is_last;
                finish  = is_last;
                case (idx_reg[1:0])
                    2'd0: byte_sel = high_reg[15:8];
                    2'd1: byte_sel = high_reg[7:0];
                    2'd2: byte_sel = low_reg[15:8];
                    default: byte_sel = low_reg[7:0];
                endcase
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    // one adler step per byte, each sum folded by a single subtract
    always_comb begin
        base_low  = restart ? a32fb_pkg::LOW_INIT : low_reg;
        base_high = restart ? a32fb_pkg::HIGH_INIT : high_reg;
        low_add   = {1'b0, base_low} + {9'd0, byte_sel};
        low_mod   = (low_add >= a32fb_pkg::ADLER_MOD) ? low_add - a32fb_pkg::ADLER_MOD
                                                      : low_add;
        high_add  = {1'b0, base_high} + low_mod;
        high_mod  = (high_add >= a32fb_pkg::ADLER_MOD) ? high_add - a32fb_pkg::ADLER_MOD
                                                       : high_add;
    end

    always_comb begin
        idx_next      = idx_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = !q_stat.empty;
        end
        if (fire) begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
            if (absorb) begin
                low_next  = low_mod[15:0];
                high_next = high_mod[15:0];
            end else if (finish) begin
                low_next  = a32fb_pkg::LOW_INIT;
                high_next = a32fb_pkg::HIGH_INIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            low_reg      <= a32fb_pkg::LOW_INIT;
            high_reg     <= a32fb_pkg::HIGH_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= byte_sel;
            m_tuser_reg <= is_done;
            m_tlast_reg <= is_last;
        end
    end

    assign pop      = fire && is_last;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
